### hdl/printf_conversion_checker_macros.svh
// Assertion helpers for the printf conversion checker.
`ifndef PRINTF_CONVERSION_CHECKER_MACROS_SVH
`define PRINTF_CONVERSION_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pcc assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pcc assertion failed one cycle later");

`endif

### hdl/pcc_pkg.sv
package pcc_pkg;

    // Longest string position that the index counter keeps.
    localparam int MAX_LEN = 256;
    localparam int IDX_W   = $clog2(MAX_LEN + 1);
    localparam int TAIL_W  = 9;
    localparam int CHAR_W  = 8;

    // Characters that the parser recognizes.
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25; // '%'
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E; // '.'
    localparam logic [CHAR_W-1:0] CH_ELL   = 8'h6C; // 'l'
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30; // '0'
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39; // '9'
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D; // '-'
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B; // '+'
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20; // ' '
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23; // '#'
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h27; // '\''
    localparam logic [CHAR_W-1:0] CH_LC_D  = 8'h64; // 'd'
    localparam logic [CHAR_W-1:0] CH_LC_I  = 8'h69; // 'i'
    localparam logic [CHAR_W-1:0] CH_LC_U  = 8'h75; // 'u'
    localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78; // 'x'
    localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58; // 'X'
    localparam logic [CHAR_W-1:0] CH_LC_O  = 8'h6F; // 'o'
    localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66; // 'f'
    localparam logic [CHAR_W-1:0] CH_LC_G  = 8'h67; // 'g'
    localparam logic [CHAR_W-1:0] CH_LC_E  = 8'h65; // 'e'
    localparam logic [CHAR_W-1:0] CH_UC_E  = 8'h45; // 'E'
    localparam logic [CHAR_W-1:0] CH_UC_G  = 8'h47; // 'G'

    typedef enum logic [2:0] {
        PH_PLAIN,
        PH_PCT,
        PH_WIDTH,
        PH_PREC,
        PH_CONV,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_INT  = 2'd1,
        ST_DBL  = 2'd2,
        ST_BAD  = 2'd3
    } t_status;

    typedef struct packed {
        logic    is_zero;
        logic    is_pct;
        logic    is_flag;
        logic    is_digit;
        logic    is_dot;
        logic    is_ell;
        t_status kind;     // ST_INT, ST_DBL, or ST_NONE for no conversion letter
    } t_char_class;

    typedef struct packed {
        logic              have;
        t_status           status;
        logic [TAIL_W-1:0] tail;
    } t_result;

endpackage

### hdl/pcc_char_class.sv
module pcc_char_class
    import pcc_pkg::*;
(
    input  logic [CHAR_W-1:0] i_char_code,
    output t_char_class       o_class
);

    always_comb begin
        o_class.is_zero  = (i_char_code == CH_NUL);
        o_class.is_pct   = (i_char_code == CH_PCT);
        o_class.is_flag  = (i_char_code == CH_ZERO)  || (i_char_code == CH_MINUS) ||
                           (i_char_code == CH_PLUS)  || (i_char_code == CH_SPACE) ||
                           (i_char_code == CH_HASH)  || (i_char_code == CH_QUOTE);
        o_class.is_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        o_class.is_dot   = (i_char_code == CH_DOT);
        o_class.is_ell   = (i_char_code == CH_ELL);
        if ((i_char_code == CH_LC_D) || (i_char_code == CH_LC_I) ||
            (i_char_code == CH_LC_U) || (i_char_code == CH_LC_X) ||
            (i_char_code == CH_UC_X) || (i_char_code == CH_LC_O)) begin
            o_class.kind = ST_INT;
        end else if ((i_char_code == CH_LC_F) || (i_char_code == CH_LC_G) ||
                     (i_char_code == CH_LC_E) || (i_char_code == CH_UC_E) ||
                     (i_char_code == CH_UC_G)) begin
            o_class.kind = ST_DBL;
        end else begin
            o_class.kind = ST_NONE;
        end
    end

endmodule

### hdl/pcc_parser.sv
module pcc_parser
    import pcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_enable,
    input  t_char_class i_class,
    input  logic        i_last,
    output t_result     o_result
);

    t_phase            r_phase;
    t_phase            n_phase;
    logic [IDX_W-1:0]  r_index;
    logic [IDX_W-1:0]  n_index;
    logic              pending;
    logic [IDX_W-1:0]  tail_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_index <= '0;
        end else if (i_enable) begin
            r_phase <= n_phase;
            r_index <= n_index;
        end
    end

    // Position just after the current byte, held at the saturation limit.
    assign tail_idx = (r_index == IDX_W'(MAX_LEN)) ? IDX_W'(MAX_LEN) : IDX_W'(r_index + 1'b1);

    // The phases fall through in order: a byte that an optional element
    // does not take is offered to the next element in the same cycle.
    always_comb begin
        n_phase         = r_phase;
        pending         = 1'b1;
        o_result.have   = 1'b0;
        o_result.status = ST_NONE;
        o_result.tail   = '0;

        unique case (r_phase)
            PH_PLAIN: begin
                pending = 1'b0;
                if (i_class.is_zero) begin
                    o_result.have = 1'b1;
                    n_phase       = PH_DONE;
                end else if (i_class.is_pct) begin
                    n_phase = PH_PCT;
                end
            end
            PH_PCT: begin
                if (i_class.is_zero) begin
                    pending         = 1'b0;
                    o_result.have   = 1'b1;
                    o_result.status = ST_BAD;
                    n_phase         = PH_DONE;
                end else if (i_class.is_pct) begin
                    pending = 1'b0;
                    n_phase = PH_PLAIN;
                end else if (i_class.is_flag) begin
                    pending = 1'b0;
                    n_phase = PH_WIDTH;
                end else begin
                    n_phase = PH_WIDTH;
                end
            end
            PH_WIDTH, PH_PREC, PH_CONV: begin
            end
            PH_DONE: begin
                pending = 1'b0;
            end
            default: begin
                pending = 1'b0;
            end
        endcase

        if (pending && (n_phase == PH_WIDTH)) begin
            if (i_class.is_zero) begin
                pending         = 1'b0;
                o_result.have   = 1'b1;
                o_result.status = ST_BAD;
                n_phase         = PH_DONE;
            end else if (i_class.is_digit) begin
                pending = 1'b0;
            end else if (i_class.is_dot) begin
                pending = 1'b0;
                n_phase = PH_PREC;
            end else begin
                n_phase = PH_PREC;
            end
        end

        if (pending && (n_phase == PH_PREC)) begin
            if (i_class.is_zero) begin
                pending         = 1'b0;
                o_result.have   = 1'b1;
                o_result.status = ST_BAD;
                n_phase         = PH_DONE;
            end else if (i_class.is_digit) begin
                pending = 1'b0;
            end else if (i_class.is_ell) begin
                pending = 1'b0;
                n_phase = PH_CONV;
            end else begin
                n_phase = PH_CONV;
            end
        end

        if (pending && (n_phase == PH_CONV)) begin
            o_result.have = 1'b1;
            n_phase       = PH_DONE;
            if (i_class.kind != ST_NONE) begin
                o_result.status = i_class.kind;
                o_result.tail   = TAIL_W'(tail_idx);
            end else begin
                o_result.status = ST_BAD;
            end
        end

        n_index = (r_index < IDX_W'(MAX_LEN)) ? IDX_W'(r_index + 1'b1) : r_index;

        // The last byte closes the string whatever was decided before.
        if (i_last) begin
            if (!o_result.have && (n_phase != PH_DONE)) begin
                o_result.have   = 1'b1;
                o_result.status = (n_phase == PH_PLAIN) ? ST_NONE : ST_BAD;
                o_result.tail   = '0;
            end
            n_phase = PH_PLAIN;
            n_index = '0;
        end
    end

endmodule

### hdl/printf_conversion_checker.sv
// Channel   Direction  Fields (lowest bit up)                       Marker
// s_axis    in         tdata: char_code[7:0]                        tlast: is_last
// m_axis    out        tdata: status[1:0], tail_position[10:2], 0s  none
//
// One item is taken per cycle while s_axis_tready is high. Each accepted character
// waits in the input register, then the parser updates its phase and position counter
// and loads the result register as the character leaves the input register.
// Reset (synchronous, active low) returns the parser to plain text at index 0.
// A stalled output holds its result while one more item waits in the input
// register; only then does s_axis_tready drop.
`include "printf_conversion_checker_macros.svh"

module printf_conversion_checker
    import pcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // is_last

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [1:0] status, [10:2] tail_position, rest zero
);

    // Input register: holds one character until the parser can take it.
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    // Result register: holds one result until the consumer takes it.
    logic              r_out_valid;
    t_status           r_out_status;
    logic [TAIL_W-1:0] r_out_tail;

    logic              in_accept;
    logic              advance;
    t_char_class       char_class;
    t_result           result;

    // The parser moves whenever a character waits and the result register is free or being drained.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    pcc_char_class u_char_class (
        .i_char_code (r_in_char),
        .o_class     (char_class)
    );

    pcc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (advance),
        .i_class  (char_class),
        .i_last   (r_in_last),
        .o_result (result)
    );

    // Most characters produce no result; the register then simply empties.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.have;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.have) begin
            r_out_status <= result.status;
            r_out_tail   <= result.tail;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_tail, r_out_status};

    // A successful conversion always points past at least one character.
    `PCC_ASSERT_SAME(a_tail_nonzero_on_success, i_clk, i_rst_n,
        r_out_valid && ((r_out_status == ST_INT) || (r_out_status == ST_DBL)),
        r_out_tail != '0)
    // No conversion and malformed results carry a zero position.
    `PCC_ASSERT_SAME(a_tail_zero_on_failure, i_clk, i_rst_n,
        r_out_valid && ((r_out_status == ST_NONE) || (r_out_status == ST_BAD)),
        r_out_tail == '0)
    // A full input register facing a stalled output must refuse new items.
    `PCC_ASSERT_SAME(a_no_overrun, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !m_axis_tready,
        !s_axis_tready)
    // A stalled parser keeps its pending character.
    `PCC_ASSERT_NEXT(a_hold_pending, i_clk, i_rst_n,
        r_in_valid && !advance,
        r_in_valid && $stable(r_in_char) && $stable(r_in_last))

endmodule

### test/printf_conversion_checker_test.sv
module printf_conversion_checker_test;

    import pcc_pkg::*;

    // A run with no handshake on either side for this many cycles is taken as a hang.
    // The longest correct quiet stretch is a source gap or a sink stall, plus the time
    // an item takes to pass the input and result registers of the block.
    localparam int unsigned IDLE_LIMIT = 200;

    // Cycles to wait after the last expected result, enough for a stray result that
    // should not be there to show.
    localparam int unsigned DRAIN_CYCLES = 12;

    // One character of a format string together with the gap the source waits
    // before offering it.
    typedef struct {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
        int unsigned       gap;
    } t_format_char;

    // One outcome of a scan as the block reports it.
    typedef struct {
        t_status           status;
        logic [TAIL_W-1:0] tail;
    } t_scan_outcome;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;

    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = 8'h00;   // [7:0] char_code
    logic              s_axis_tlast = 1'b0;    // is_last

    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;           // [1:0] status, [10:2] tail_position

    // Characters waiting to be offered, and outcomes waiting to be seen.
    t_format_char      pending_chars[$];
    t_scan_outcome     expected_outcomes[$];

    // The scanner state that the prediction keeps alongside the block.
    t_phase            scan_phase = PH_PLAIN;
    int unsigned       scan_pos = 0;

    // Source pacing: the largest gap drawn for new characters while the queue is built.
    int unsigned       src_gap_max = 10;
    int unsigned       src_gap_count = 0;

    // Sink pacing: the largest stall drawn after each result, and the stall in progress.
    int unsigned       sink_stall_max = 10;
    int unsigned       sink_stall_left = 0;
    int unsigned       sink_stall_next;

    int unsigned       mismatch_count = 0;
    int unsigned       idle_cycles = 0;

    printf_conversion_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Works out what one accepted character does to the scanner, and queues the
    // outcome when the character decides one. The phases fall through within one
    // character: a non-flag byte after '%' is tried as width, then as precision,
    // and finally as the conversion letter.
    task automatic predict_conversion(input logic [CHAR_W-1:0] c, input logic last);
        t_phase        phase;
        int unsigned   pos;
        logic          pending;
        logic          found;
        logic          digit;
        logic          flag;
        t_status       verdict;
        t_status       letter;
        int unsigned   tail;
        t_scan_outcome outcome;
        phase   = scan_phase;
        pos     = scan_pos;
        pending = 1'b1;
        found   = 1'b0;
        verdict = ST_NONE;
        tail    = 0;
        digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        flag    = (c == CH_ZERO) || (c == CH_MINUS) || (c == CH_PLUS) ||
                  (c == CH_SPACE) || (c == CH_HASH) || (c == CH_QUOTE);
        case (c)
            CH_LC_D, CH_LC_I, CH_LC_U, CH_LC_X, CH_UC_X, CH_LC_O: letter = ST_INT;
            CH_LC_F, CH_LC_G, CH_LC_E, CH_UC_E, CH_UC_G:          letter = ST_DBL;
            default:                                              letter = ST_NONE;
        endcase

        case (phase)
            PH_PLAIN: begin
                pending = 1'b0;
                if (c == CH_NUL) begin
                    found   = 1'b1;
                    verdict = ST_NONE;
                    phase   = PH_DONE;
                end else if (c == CH_PCT) begin
                    phase = PH_PCT;
                end
            end
            PH_PCT: begin
                if (c == CH_NUL) begin
                    pending = 1'b0;
                    found   = 1'b1;
                    verdict = ST_BAD;
                    phase   = PH_DONE;
                end else if (c == CH_PCT) begin
                    // A doubled percent sign is plain text.
                    pending = 1'b0;
                    phase   = PH_PLAIN;
                end else if (flag) begin
                    pending = 1'b0;
                    phase   = PH_WIDTH;
                end else begin
                    phase = PH_WIDTH;
                end
            end
            PH_DONE: begin
                pending = 1'b0;
            end
            default: begin
            end
        endcase

        if (pending && phase == PH_WIDTH) begin
            if (c == CH_NUL) begin
                pending = 1'b0;
                found   = 1'b1;
                verdict = ST_BAD;
                phase   = PH_DONE;
            end else if (digit) begin
                pending = 1'b0;
            end else if (c == CH_DOT) begin
                pending = 1'b0;
                phase   = PH_PREC;
            end else begin
                phase = PH_PREC;
            end
        end

        if (pending && phase == PH_PREC) begin
            if (c == CH_NUL) begin
                pending = 1'b0;
                found   = 1'b1;
                verdict = ST_BAD;
                phase   = PH_DONE;
            end else if (digit) begin
                pending = 1'b0;
            end else if (c == CH_ELL) begin
                pending = 1'b0;
                phase   = PH_CONV;
            end else begin
                phase = PH_CONV;
            end
        end

        // Whatever reaches this point must be the conversion letter.
        if (pending && phase == PH_CONV) begin
            found = 1'b1;
            phase = PH_DONE;
            if (letter != ST_NONE) begin
                verdict = letter;
                tail    = (pos + 1 > MAX_LEN) ? MAX_LEN : pos + 1;
            end else begin
                verdict = ST_BAD;
            end
        end

        if (pos < MAX_LEN) begin
            pos = pos + 1;
        end

        // The last marker closes the string: an undecided scan reports here, and the
        // scanner starts over for the next string.
        if (last) begin
            if (!found && phase != PH_DONE) begin
                found   = 1'b1;
                verdict = (phase == PH_PLAIN) ? ST_NONE : ST_BAD;
                tail    = 0;
            end
            phase = PH_PLAIN;
            pos   = 0;
        end

        scan_phase = phase;
        scan_pos   = pos;
        if (found) begin
            outcome.status = verdict;
            outcome.tail   = tail[TAIL_W-1:0];
            expected_outcomes.push_back(outcome);
        end
    endtask

    task automatic add_char(input logic [CHAR_W-1:0] c, input logic last);
        t_format_char item;
        item.char_code = c;
        item.is_last   = last;
        item.gap       = $urandom_range(0, src_gap_max);
        pending_chars.push_back(item);
    endtask

    task automatic add_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++) begin
            add_char(s[i], close && (i == s.len() - 1));
        end
    endtask

    // A byte that is plain text: neither the terminator nor a percent sign.
    task automatic add_plain(input int unsigned count);
        logic [CHAR_W-1:0] c;
        for (int i = 0; i < count; i++) begin
            do begin
                c = CHAR_W'($urandom_range(1, 255));
            end while (c == CH_PCT);
            add_char(c, 1'b0);
        end
    endtask

    // One random format string. Most are well formed with random content, some are
    // cut short or end in a terminator, and the rest are noise bytes.
    task automatic add_random_string();
        logic [CHAR_W-1:0] conv[$];
        int unsigned       kind;
        int unsigned       cut;
        int unsigned       count;
        logic [CHAR_W-1:0] c;
        kind = $urandom_range(0, 99);

        // Plain text in front, with an occasional doubled percent sign.
        count = $urandom_range(0, 5);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                add_char(CH_PCT, 1'b0);
                add_char(CH_PCT, 1'b0);
            end else begin
                add_plain(1);
            end
        end

        if (kind < 15) begin
            count = $urandom_range(1, 8);
            for (int i = 0; i < count; i++) begin
                add_char(CHAR_W'($urandom_range(0, 255)), i == count - 1);
            end
            return;
        end

        conv.push_back(CH_PCT);
        if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 5))
                0:       c = CH_ZERO;
                1:       c = CH_MINUS;
                2:       c = CH_PLUS;
                3:       c = CH_SPACE;
                4:       c = CH_HASH;
                default: c = CH_QUOTE;
            endcase
            conv.push_back(c);
        end
        count = $urandom_range(0, 3);
        for (int i = 0; i < count; i++) begin
            conv.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 1) == 1) begin
            conv.push_back(CH_DOT);
            count = $urandom_range(0, 3);
            for (int i = 0; i < count; i++) begin
                conv.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
            end
        end
        case ($urandom_range(0, 19))
            0:                   begin conv.push_back(CH_ELL); conv.push_back(CH_ELL); end
            1, 2, 3, 4, 5, 6:    conv.push_back(CH_ELL);
            default:             begin end
        endcase
        if ($urandom_range(0, 9) == 0) begin
            conv.push_back(CHAR_W'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 10))
                0:       c = CH_LC_D;
                1:       c = CH_LC_I;
                2:       c = CH_LC_U;
                3:       c = CH_LC_X;
                4:       c = CH_UC_X;
                5:       c = CH_LC_O;
                6:       c = CH_LC_F;
                7:       c = CH_LC_G;
                8:       c = CH_LC_E;
                9:       c = CH_UC_E;
                default: c = CH_UC_G;
            endcase
            conv.push_back(c);
        end

        if (kind < 30) begin
            // A broken conversion: cut before the letter, then either the last marker
            // lands inside it or a terminator follows.
            cut = $urandom_range(1, conv.size() - 1);
            for (int i = 0; i < cut; i++) begin
                add_char(conv[i], 1'b0);
            end
            if ($urandom_range(0, 1) == 1) begin
                add_char(CH_NUL, 1'($urandom_range(0, 1)));
            end
        end else begin
            foreach (conv[i]) begin
                add_char(conv[i], 1'b0);
            end
        end

        // Trailing bytes, which the block ignores once the outcome is known.
        count = $urandom_range(0, 3);
        for (int i = 0; i < count; i++) begin
            add_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
        end
        add_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // Source side. Each character waits out its own gap after the previous one was
    // taken; an offered character is held until the block accepts it, and the
    // prediction is made at the accepting edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap_count <= 0;
            scan_phase = PH_PLAIN;
            scan_pos   = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_conversion(s_axis_tdata, s_axis_tlast);
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // Hold the current item.
            end else if (pending_chars.size() != 0 && src_gap_count >= pending_chars[0].gap) begin
                s_axis_tdata  <= pending_chars[0].char_code;
                s_axis_tlast  <= pending_chars[0].is_last;
                s_axis_tvalid <= 1'b1;
                src_gap_count <= 0;
                void'(pending_chars.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
                if (pending_chars.size() != 0) begin
                    src_gap_count <= src_gap_count + 1;
                end
            end
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Sink side. After each accepted result the sink stalls for a drawn number of
    // cycles; now and then it switches between stalling and never stalling, so that
    // back-to-back stretches occur too. Every result is checked against the oldest
    // outcome still waiting.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready   <= 1'b0;
            sink_stall_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch($sformatf("no result expected, got status %0d tail %0d",
                                              m_axis_tdata[1:0], m_axis_tdata[10:2]));
                end else if (m_axis_tdata[1:0] != expected_outcomes[0].status ||
                             m_axis_tdata[10:2] != expected_outcomes[0].tail) begin
                    report_mismatch($sformatf("expected status %0d tail %0d, got status %0d tail %0d",
                                              expected_outcomes[0].status,
                                              expected_outcomes[0].tail,
                                              m_axis_tdata[1:0], m_axis_tdata[10:2]));
                end
                if (expected_outcomes.size() != 0) begin
                    void'(expected_outcomes.pop_front());
                end
                if ($urandom_range(0, 31) == 0) begin
                    sink_stall_max <= (sink_stall_max == 0) ? 10 : 0;
                end
                sink_stall_next = $urandom_range(0, sink_stall_max);
            end else if (sink_stall_left != 0) begin
                sink_stall_next = sink_stall_left - 1;
            end else begin
                sink_stall_next = 0;
            end
            sink_stall_left <= sink_stall_next;
            m_axis_tready   <= (sink_stall_next == 0);
        end
    end

    // Watchdog: a long run of cycles with no handshake at all means the block hangs.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** printf_conversion_checker: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        // Directed strings: simple and fully decorated conversions, a doubled percent
        // sign, a lone percent sign at the end, a terminator before the last marker
        // with a byte after it, a second 'l', and a plain byte of all ones that ends
        // the string by its last marker alone.
        src_gap_max = 0;
        add_text("%d", 1'b1);
        add_text("%-5.3lX", 1'b1);
        src_gap_max = 10;
        add_text("%%%g", 1'b1);
        add_text("%", 1'b1);
        add_text("a", 1'b0);
        add_char(CH_NUL, 1'b0);
        add_text("z", 1'b1);
        add_text("%ll", 1'b0);
        add_text("d", 1'b1);
        add_char(8'hFF, 1'b1);

        // One long string, so that the position counter saturates before the
        // conversion letter arrives.
        src_gap_max = 2;
        add_plain(260);
        add_text("%5d", 1'b1);

        // Random strings; the source alternates between back-to-back stretches and gaps.
        while (pending_chars.size() < 520) begin
            src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            for (int i = 0; i < 6; i++) begin
                add_random_string();
            end
        end

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every character is taken and every outcome has arrived, then
        // give a stray result time to show.
        while (pending_chars.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
            $display("** printf_conversion_checker: PASSED **");
        end else begin
            $display("** printf_conversion_checker: FAILED **");
        end
        $finish;
    end

endmodule
